// ===== design/sirt_pkg.sv =====
// ============================================================================
// sirt_pkg
// Shared widths, constants, types and the digit glyph function of the
// signed integer to radix text converter.
// ============================================================================
package sirt_pkg;

    localparam int VALUE_WIDTH  = 64;
    localparam int VALUE_PORT_W = 64;
    localparam int RADIX_W      = 5;
    localparam int CHAR_W       = 8;
    localparam int DIGIT_W      = 4;

    localparam int NUM_BYTES = (VALUE_WIDTH + 7) / 8;
    localparam int MAG_W     = NUM_BYTES * 8;
    localparam int BIDX_W    = (NUM_BYTES > 1) ? $clog2(NUM_BYTES) : 1;

    localparam int DIG_DEPTH = VALUE_WIDTH;
    localparam int DADDR_W   = $clog2(DIG_DEPTH);
    localparam int DCNT_W    = $clog2(DIG_DEPTH + 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(16);
    localparam logic [DIGIT_W-1:0] DIGIT_TEN = DIGIT_W'(10);

    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2D;

    typedef struct packed {
        logic [MAG_W-1:0]   mag;
        logic               negative;
        logic [RADIX_W-1:0] radix;
        logic [BIDX_W-1:0]  top;
    } job_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_EMIT
    } back_state_t;

    function automatic logic [CHAR_W-1:0] digit_glyph(input logic [DIGIT_W-1:0] d);
        if (d < DIGIT_TEN)
            return CHAR_ZERO + CHAR_W'(d);
        else
            return CHAR_UPPER_A + CHAR_W'(d - DIGIT_TEN);
    endfunction

endpackage

// ===== design/sirt_ifs.sv =====
// ============================================================================
// sirt channel interfaces
// Valid/ready channels for the number beat and the text character beat.
// ============================================================================
interface sirt_in_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [sirt_pkg::VALUE_PORT_W-1:0] value;
    logic [sirt_pkg::RADIX_W-1:0]           radix;

    modport source (output valid, output value, output radix, input ready);
    modport sink   (input valid, input value, input radix, output ready);
endinterface

interface sirt_out_if;
    logic                        valid;
    logic                        ready;
    logic [sirt_pkg::CHAR_W-1:0] character;
    logic                        last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

// ===== design/sirt_ram.sv =====
// ============================================================================
// sirt_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module sirt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== design/sirt_front.sv =====
// ============================================================================
// sirt_front
// Accepts number beats, clamps the radix, takes the saturated magnitude and
// finds its top non-zero byte.
// ============================================================================
module sirt_front (
    sirt_in_if.sink               number,
    output logic                  push_valid,
    input  logic                  push_ready,
    output sirt_pkg::job_t        push_job
);

    logic [sirt_pkg::VALUE_WIDTH-1:0] raw;
    logic [sirt_pkg::VALUE_WIDTH-1:0] neg_raw;
    logic [sirt_pkg::VALUE_WIDTH-1:0] mag;
    logic [sirt_pkg::MAG_W-1:0]       mag_pad;
    logic                             negative;
    logic [sirt_pkg::RADIX_W-1:0]     radix;
    logic [sirt_pkg::BIDX_W-1:0]      top;

    assign raw      = number.value[sirt_pkg::VALUE_WIDTH-1:0];
    assign negative = raw[sirt_pkg::VALUE_WIDTH-1];
    assign neg_raw  = ~raw + sirt_pkg::VALUE_WIDTH'(1);

    always_comb
    begin
        if (!negative)
            mag = raw;
        else if (neg_raw[sirt_pkg::VALUE_WIDTH-1])
            mag = neg_raw - sirt_pkg::VALUE_WIDTH'(1);
        else
            mag = neg_raw;
    end

    assign mag_pad = sirt_pkg::MAG_W'(mag);

    always_comb
    begin
        if (number.radix < sirt_pkg::RADIX_MIN)
            radix = sirt_pkg::RADIX_MIN;
        else if (number.radix > sirt_pkg::RADIX_MAX)
            radix = sirt_pkg::RADIX_MAX;
        else
            radix = number.radix;
    end

    always_comb
    begin
        top = '0;
        for (int i = 0; i < sirt_pkg::NUM_BYTES; i++)
        begin
            if (mag_pad[i*8 +: 8] != 8'h00)
                top = sirt_pkg::BIDX_W'(i);
        end
    end

    assign push_valid        = number.valid;
    assign number.ready      = push_ready;
    assign push_job.mag      = mag_pad;
    assign push_job.negative = negative;
    assign push_job.radix    = radix;
    assign push_job.top      = top;

endmodule

// ===== design/sirt_queue.sv =====
// ============================================================================
// sirt_queue
// Two-entry job queue between the front and the conversion back end.
// ============================================================================
module sirt_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  sirt_pkg::job_t push_job,
    output logic           pop_valid,
    input  logic           pop_ready,
    output sirt_pkg::job_t pop_job
);

    sirt_pkg::job_t              entry_reg [sirt_pkg::QUEUE_DEPTH];
    logic [sirt_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [sirt_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [sirt_pkg::QCNT_W-1:0] count_reg;
    logic                        push;
    logic                        pop;

    assign push_ready = (count_reg != sirt_pkg::QCNT_W'(sirt_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + sirt_pkg::QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + sirt_pkg::QPTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + sirt_pkg::QCNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - sirt_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

endmodule

// ===== design/sirt_back.sv =====
// ============================================================================
// sirt_back
// Divides the magnitude by the radix a byte per cycle, stacks the digits in
// a RAM and streams them back out most significant first.
// ============================================================================
module sirt_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           job_valid,
    output logic           job_ready,
    input  sirt_pkg::job_t job,
    sirt_out_if.source     text
);

    sirt_pkg::back_state_t        state_reg, state_next;
    logic [sirt_pkg::MAG_W-1:0]   mag_reg, mag_next;
    logic                         neg_reg, neg_next;
    logic [sirt_pkg::RADIX_W-1:0] radix_reg, radix_next;
    logic [sirt_pkg::BIDX_W-1:0]  top_reg, top_next;
    logic [sirt_pkg::BIDX_W-1:0]  b_reg, b_next;
    logic [sirt_pkg::DIGIT_W-1:0] rem_reg, rem_next;
    logic [sirt_pkg::DCNT_W-1:0]  dcnt_reg, dcnt_next;
    logic [sirt_pkg::DCNT_W-1:0]  rd_cnt_reg, rd_cnt_next;
    logic                         sign_pend_reg, sign_pend_next;
    logic                         pend_reg, pend_next;
    logic                         pend_last_reg, pend_last_next;
    logic                         out_valid_reg, out_valid_next;
    logic [sirt_pkg::CHAR_W-1:0]  char_reg, char_next;
    logic                         last_reg, last_next;

    logic [7:0]                   div_byte;
    logic [7:0]                   q_byte;
    logic [sirt_pkg::DIGIT_W-1:0] rem_div;
    logic [sirt_pkg::RADIX_W-1:0] trial;
    logic [sirt_pkg::MAG_W-1:0]   quot_mag;
    logic                         quot_zero;
    logic [sirt_pkg::BIDX_W-1:0]  top_shrunk;

    logic                         ram_we;
    logic                         rd_issue;
    logic [sirt_pkg::DIGIT_W-1:0] rd_digit;
    logic                         out_free;
    logic                         load_sign;
    logic                         load_dig;

    logic [sirt_pkg::DCNT_W-1:0]  rd_cnt_dec;
    logic [sirt_pkg::DADDR_W-1:0] rd_addr_w;

    sirt_ram #(
        .WIDTH (sirt_pkg::DIGIT_W),
        .DEPTH (sirt_pkg::DIG_DEPTH)
    ) u_digits (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (dcnt_reg[sirt_pkg::DADDR_W-1:0]),
        .wr_data (rem_div),
        .rd_en   (rd_issue),
        .rd_addr (rd_addr_w),
        .rd_data (rd_digit)
    );

    assign rd_cnt_dec = rd_cnt_reg - sirt_pkg::DCNT_W'(1);
    assign rd_addr_w  = rd_cnt_dec[sirt_pkg::DADDR_W-1:0];

    // restoring division of one byte, quotient bits replace dividend bits
    always_comb
    begin
        div_byte = mag_reg[b_reg*8 +: 8];
        rem_div  = rem_reg;
        q_byte   = '0;
        trial    = '0;
        for (int i = 7; i >= 0; i--)
        begin
            trial = {rem_div, div_byte[i]};
            if (trial >= radix_reg)
            begin
                q_byte[i] = 1'b1;
                trial     = trial - radix_reg;
            end
            rem_div = trial[sirt_pkg::DIGIT_W-1:0];
        end
        quot_mag = mag_reg;
        quot_mag[b_reg*8 +: 8] = q_byte;
    end

    assign quot_zero = (quot_mag == '0);
    assign top_shrunk = ((quot_mag[top_reg*8 +: 8] == 8'h00) && (top_reg != '0))
                      ? top_reg - sirt_pkg::BIDX_W'(1) : top_reg;

    assign out_free  = !out_valid_reg || text.ready;
    assign load_sign = (state_reg == sirt_pkg::BK_EMIT) && sign_pend_reg && out_free;
    assign load_dig  = (state_reg == sirt_pkg::BK_EMIT) && !sign_pend_reg && pend_reg
                     && out_free;
    assign rd_issue  = (state_reg == sirt_pkg::BK_EMIT) && (rd_cnt_reg != '0)
                     && (!pend_reg || load_dig);

    always_comb
    begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        radix_next     = radix_reg;
        top_next       = top_reg;
        b_next         = b_reg;
        rem_next       = rem_reg;
        dcnt_next      = dcnt_reg;
        rd_cnt_next    = rd_cnt_reg;
        sign_pend_next = sign_pend_reg;
        pend_next      = pend_reg;
        pend_last_next = pend_last_reg;
        job_ready      = 1'b0;
        ram_we         = 1'b0;

        unique case (state_reg)
            sirt_pkg::BK_IDLE:
            begin
                job_ready = 1'b1;
                if (job_valid)
                begin
                    mag_next   = job.mag;
                    neg_next   = job.negative;
                    radix_next = job.radix;
                    top_next   = job.top;
                    b_next     = job.top;
                    rem_next   = '0;
                    dcnt_next  = '0;
                    state_next = sirt_pkg::BK_DIV;
                end
            end
            sirt_pkg::BK_DIV:
            begin
                mag_next = quot_mag;
                if (b_reg == '0)
                begin
                    ram_we    = 1'b1;
                    dcnt_next = dcnt_reg + sirt_pkg::DCNT_W'(1);
                    rem_next  = '0;
                    if (quot_zero)
                    begin
                        state_next     = sirt_pkg::BK_EMIT;
                        rd_cnt_next    = dcnt_reg + sirt_pkg::DCNT_W'(1);
                        sign_pend_next = neg_reg;
                        pend_next      = 1'b0;
                    end
                    else
                    begin
                        top_next = top_shrunk;
                        b_next   = top_shrunk;
                    end
                end
                else
                begin
                    b_next   = b_reg - sirt_pkg::BIDX_W'(1);
                    rem_next = rem_div;
                end
            end
            sirt_pkg::BK_EMIT:
            begin
                if (load_sign)
                    sign_pend_next = 1'b0;
                if (rd_issue)
                begin
                    rd_cnt_next    = rd_cnt_dec;
                    pend_next      = 1'b1;
                    pend_last_next = (rd_cnt_reg == sirt_pkg::DCNT_W'(1));
                end
                else if (load_dig)
                begin
                    pend_next = 1'b0;
                end
                if (load_dig && pend_last_reg)
                    state_next = sirt_pkg::BK_IDLE;
            end
            default:
            begin
                state_next = sirt_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        if (load_sign)
        begin
            out_valid_next = 1'b1;
            char_next      = sirt_pkg::CHAR_MINUS;
            last_next      = 1'b0;
        end
        else if (load_dig)
        begin
            out_valid_next = 1'b1;
            char_next      = sirt_pkg::digit_glyph(rd_digit);
            last_next      = pend_last_reg;
        end
        else if (text.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sirt_pkg::BK_IDLE;
            dcnt_reg      <= '0;
            rd_cnt_reg    <= '0;
            sign_pend_reg <= 1'b0;
            pend_reg      <= 1'b0;
            pend_last_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            b_reg         <= '0;
            top_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            dcnt_reg      <= dcnt_next;
            rd_cnt_reg    <= rd_cnt_next;
            sign_pend_reg <= sign_pend_next;
            pend_reg      <= pend_next;
            pend_last_reg <= pend_last_next;
            out_valid_reg <= out_valid_next;
            b_reg         <= b_next;
            top_reg       <= top_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg   <= mag_next;
        neg_reg   <= neg_next;
        radix_reg <= radix_next;
        rem_reg   <= rem_next;
        char_reg  <= char_next;
        last_reg  <= last_next;
    end

    assign text.valid     = out_valid_reg;
    assign text.character = char_reg;
    assign text.last      = last_reg;

    a_rem_below_radix: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sirt_pkg::BK_DIV) |-> ({1'b0, rem_reg} < radix_reg))
        else $error("remainder not below radix");

    a_byte_within_top: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sirt_pkg::BK_DIV) |-> (b_reg <= top_reg))
        else $error("byte cursor above top byte");

    a_digit_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sirt_pkg::BK_DIV)
        |-> (dcnt_reg < sirt_pkg::DCNT_W'(sirt_pkg::DIG_DEPTH)))
        else $error("digit buffer overrun");

    a_read_pending: assert property (@(posedge clk) disable iff (!rst_n)
        rd_issue |=> pend_reg)
        else $error("issued read not pending");

    a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (load_dig && pend_last_reg) |-> (rd_cnt_reg == '0))
        else $error("last digit loaded with digits left");

endmodule

// ===== design/signed_integer_to_radix_text.sv =====
// ============================================================================
// signed_integer_to_radix_text
// The queue registers each job; the back end then divides from the current top
// byte down to byte 0 for each digit, up to 8 bytes per digit and 63 digits,
// then streams one character a cycle while the receiver is ready.
// Throughput: one number at a time in the back end, up to two queued ahead.
// Reset clears control state; the digit RAM is not cleared.
// ============================================================================
module signed_integer_to_radix_text (
    input  logic      clk,
    input  logic      rst_n,
    sirt_in_if.sink   number,
    sirt_out_if.source text
);

    logic           push_valid;
    logic           push_ready;
    sirt_pkg::job_t push_job;
    logic           pop_valid;
    logic           pop_ready;
    sirt_pkg::job_t pop_job;

    sirt_front u_front (
        .number     (number),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    sirt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    sirt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (pop_valid),
        .job_ready (pop_ready),
        .job       (pop_job),
        .text      (text)
    );

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for the signed integer to radix text converter. Numbers
// and bases go in on the number channel; an in-bench conversion predicts the
// character beats, and every text beat is checked in order against them.
// ============================================================================
module tb;

    import sirt_pkg::*;

    localparam int NUM_ITEMS     = 210;
    localparam int HOLD_AT       = 40;
    localparam int HOLD_CYCLES   = 3000;
    localparam int SETTLE_CYCLES = 600;
    localparam int MAX_IDLE      = 16;

    localparam logic [VALUE_PORT_W-1:0] VALUE_MAX = {1'b0, {(VALUE_PORT_W-1){1'b1}}};
    localparam logic [VALUE_PORT_W-1:0] VALUE_MIN = {1'b1, {(VALUE_PORT_W-1){1'b0}}};
    localparam string GLYPHS = "0123456789ABCDEF";

    typedef struct {
        logic [VALUE_PORT_W-1:0] value;
        logic [RADIX_W-1:0]      radix;
        int unsigned             gap;
        bit                      drain;
    } number_item_t;

    typedef struct {
        logic [CHAR_W-1:0] character;
        logic              last;
    } text_beat_t;

    logic clk;
    logic rst_n;

    sirt_in_if  number_ch ();
    sirt_out_if text_ch ();

    signed_integer_to_radix_text i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .number(number_ch),
        .text  (text_ch)
    );

    number_item_t pending_numbers[$];
    text_beat_t   expected_text[$];

    int unsigned numbers_sent;
    int unsigned chars_pushed;
    int unsigned chars_seen;
    int unsigned idle_count;
    int unsigned rx_wait;
    int unsigned hold_left;
    bit          hold_done;
    int unsigned mismatches = 0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    function automatic int predict_text(input logic [VALUE_PORT_W-1:0] value,
                                        input logic [RADIX_W-1:0] radix);
        logic [63:0]       sign_bit;
        logic [63:0]       width_mask;
        logic [63:0]       raw;
        logic [63:0]       mag;
        logic [63:0]       base;
        logic [CHAR_W-1:0] digits [64];
        text_beat_t        beat;
        bit                negative;
        int                n;
        int                i;
        sign_bit   = 64'd1 << (VALUE_WIDTH - 1);
        width_mask = (sign_bit << 1) - 64'd1;
        raw        = 64'(value) & width_mask;
        if (radix < RADIX_MIN)
            base = 64'(RADIX_MIN);
        else if (radix > RADIX_MAX)
            base = 64'(RADIX_MAX);
        else
            base = 64'(radix);
        negative = (raw & sign_bit) != 64'd0;
        mag = negative ? ((~raw + 64'd1) & width_mask) : raw;
        // saturate the most negative value
        if (mag > sign_bit - 64'd1)
            mag = sign_bit - 64'd1;
        if (mag == 64'd0)
        begin
            beat.character = CHAR_ZERO;
            beat.last      = 1'b1;
            expected_text.push_back(beat);
            return 1;
        end
        n = 0;
        while (mag != 64'd0)
        begin
            digits[n] = GLYPHS[int'(mag % base)];
            mag = mag / base;
            n++;
        end
        if (negative)
        begin
            beat.character = CHAR_MINUS;
            beat.last      = 1'b0;
            expected_text.push_back(beat);
        end
        for (i = n - 1; i >= 0; i--)
        begin
            beat.character = digits[i];
            beat.last      = (i == 0);
            expected_text.push_back(beat);
        end
        return negative ? n + 1 : n;
    endfunction

    task automatic queue_number(input logic [VALUE_PORT_W-1:0] value,
                                input logic [RADIX_W-1:0] radix,
                                input int unsigned gap,
                                input bit drain);
        number_item_t item;
        item.value = value;
        item.radix = radix;
        item.gap   = gap;
        item.drain = drain;
        pending_numbers.push_back(item);
    endtask

    function automatic logic [VALUE_PORT_W-1:0] random_value();
        logic [VALUE_PORT_W-1:0] v;
        int unsigned             bits;
        case ($urandom_range(0, 5))
            0, 1: v = {$urandom, $urandom};
            2: v = VALUE_PORT_W'($urandom_range(0, 40));
            3:
            begin
                bits = $urandom_range(1, VALUE_PORT_W - 1);
                v = {$urandom, $urandom} & ((VALUE_PORT_W'(1) << bits) - 1);
            end
            4:
            begin
                case ($urandom_range(0, 2))
                    0: v = VALUE_MAX;
                    1: v = VALUE_MIN;
                    default: v = VALUE_MAX - VALUE_PORT_W'($urandom_range(0, 3));
                endcase
            end
            default: v = VALUE_PORT_W'($urandom);
        endcase
        if ($urandom_range(0, 1) == 1)
            v = -v;
        return v;
    endfunction

    function automatic logic [RADIX_W-1:0] random_radix();
        if ($urandom_range(0, 99) < 85)
            return RADIX_W'($urandom_range(2, 16));
        return RADIX_W'($urandom_range(0, 31));
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : number_driver
        int unsigned  added;
        number_item_t nxt;
        if (!rst_n)
        begin
            number_ch.valid <= 1'b0;
            number_ch.value <= '0;
            number_ch.radix <= '0;
            idle_count      <= 0;
            numbers_sent    <= 0;
            chars_pushed    <= 0;
        end
        else
        begin
            added = 0;
            if (number_ch.valid && number_ch.ready)
            begin
                added = predict_text(number_ch.value, number_ch.radix);
                chars_pushed <= chars_pushed + added;
                numbers_sent <= numbers_sent + 1;
            end
            if (!number_ch.valid || number_ch.ready)
            begin
                if (pending_numbers.size() == 0)
                    number_ch.valid <= 1'b0;
                else if (idle_count < pending_numbers[0].gap)
                begin
                    idle_count      <= idle_count + 1;
                    number_ch.valid <= 1'b0;
                end
                else if (pending_numbers[0].drain && (added != 0 || chars_pushed != chars_seen))
                    number_ch.valid <= 1'b0;
                else
                begin
                    nxt = pending_numbers.pop_front();
                    number_ch.value <= nxt.value;
                    number_ch.radix <= nxt.radix;
                    number_ch.valid <= 1'b1;
                    idle_count      <= 0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : text_monitor
        text_beat_t  want;
        int unsigned w_next;
        int unsigned h_next;
        if (!rst_n)
        begin
            text_ch.ready <= 1'b0;
            rx_wait       <= 0;
            hold_left     <= 0;
            hold_done     <= 1'b0;
            chars_seen    <= 0;
        end
        else
        begin
            w_next = rx_wait;
            h_next = hold_left;
            if (text_ch.valid && text_ch.ready)
            begin
                if (expected_text.size() == 0)
                    report_mismatch($sformatf("unexpected character 8'h%02h last %0b",
                                              text_ch.character, text_ch.last));
                else
                begin
                    want = expected_text.pop_front();
                    if (text_ch.character !== want.character)
                        report_mismatch($sformatf("character 8'h%02h, want 8'h%02h",
                                                  text_ch.character, want.character));
                    if (text_ch.last !== want.last)
                        report_mismatch($sformatf("last %0b, want %0b",
                                                  text_ch.last, want.last));
                end
                chars_seen <= chars_seen + 1;
                // no stalls in every fourth stretch of 64 beats
                w_next = ((chars_seen / 64) % 4 == 1) ? 0 : $urandom_range(0, MAX_IDLE);
            end
            else if (w_next != 0)
                w_next = w_next - 1;
            if (h_next != 0)
                h_next = h_next - 1;
            else if (!hold_done && numbers_sent == HOLD_AT)
            begin
                h_next = HOLD_CYCLES;
                hold_done <= 1'b1;
            end
            rx_wait       <= w_next;
            hold_left     <= h_next;
            text_ch.ready <= (w_next == 0 && h_next == 0);
        end
    end

    initial
    begin : stimulus
        int          i;
        int unsigned gap;
        bit          drain;
        rst_n <= 1'b0;

        queue_number(VALUE_PORT_W'(0), RADIX_W'(10), $urandom_range(0, MAX_IDLE), 1'b0);
        queue_number(VALUE_PORT_W'(0), RADIX_W'(2), $urandom_range(0, MAX_IDLE), 1'b0);
        queue_number(VALUE_PORT_W'(0), RADIX_W'(16), $urandom_range(0, MAX_IDLE), 1'b0);
        queue_number(VALUE_PORT_W'(1), RADIX_W'(2), $urandom_range(0, MAX_IDLE), 1'b0);
        queue_number(-VALUE_PORT_W'(1), RADIX_W'(10), $urandom_range(0, MAX_IDLE), 1'b0);
        queue_number(VALUE_PORT_W'(9), RADIX_W'(10), $urandom_range(0, MAX_IDLE), 1'b0);
        queue_number(VALUE_PORT_W'(10), RADIX_W'(16), $urandom_range(0, MAX_IDLE), 1'b0);
        queue_number(VALUE_PORT_W'(15), RADIX_W'(16), $urandom_range(0, MAX_IDLE), 1'b0);
        queue_number(-VALUE_PORT_W'(15), RADIX_W'(16), $urandom_range(0, MAX_IDLE), 1'b0);
        queue_number(VALUE_MAX, RADIX_W'(2), $urandom_range(0, MAX_IDLE), 1'b0);
        queue_number(-VALUE_MAX, RADIX_W'(2), $urandom_range(0, MAX_IDLE), 1'b0);
        queue_number(VALUE_MIN, RADIX_W'(2), $urandom_range(0, MAX_IDLE), 1'b0);
        queue_number(VALUE_MIN, RADIX_W'(10), $urandom_range(0, MAX_IDLE), 1'b0);
        queue_number(VALUE_MIN, RADIX_W'(16), $urandom_range(0, MAX_IDLE), 1'b0);
        queue_number(VALUE_MAX, RADIX_W'(16), $urandom_range(0, MAX_IDLE), 1'b0);
        queue_number(-VALUE_MAX, RADIX_W'(10), $urandom_range(0, MAX_IDLE), 1'b0);
        queue_number(VALUE_PORT_W'(255), RADIX_W'(0), $urandom_range(0, MAX_IDLE), 1'b0);
        queue_number(VALUE_PORT_W'(255), RADIX_W'(1), $urandom_range(0, MAX_IDLE), 1'b0);
        queue_number(VALUE_PORT_W'(255), RADIX_W'(17), $urandom_range(0, MAX_IDLE), 1'b0);
        queue_number(-VALUE_PORT_W'(255), RADIX_W'(31), $urandom_range(0, MAX_IDLE), 1'b0);
        queue_number(VALUE_PORT_W'(35), RADIX_W'(3), $urandom_range(0, MAX_IDLE), 1'b0);
        queue_number(VALUE_PORT_W'(123456789), RADIX_W'(8), $urandom_range(0, MAX_IDLE), 1'b0);
        queue_number(-VALUE_PORT_W'(4096), RADIX_W'(7), $urandom_range(0, MAX_IDLE), 1'b0);

        for (i = pending_numbers.size(); i < NUM_ITEMS; i++)
        begin
            // back-to-back stretches, and a burst around the receiver hold-off
            if ((i / 30) % 4 == 2 || (i >= HOLD_AT - 2 && i < HOLD_AT + 20))
                gap = 0;
            else
                gap = $urandom_range(0, MAX_IDLE);
            drain = (i == HOLD_AT + 22) || (i == 150);
            queue_number(random_value(), random_radix(), gap, drain);
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_numbers.size() != 0 || number_ch.valid)
            @(posedge clk);
        while (expected_text.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
